>>> hw/rtl/asrc_pkg.sv
// shared types, constants and codes of the linear resampler
// used by every module of the block; depends on nothing
package asrc_pkg;

    localparam int RING_DEPTH_DEF     = 256;
    localparam int MAX_FRAME_DEF      = 64;
    localparam int CONTROL_PERIOD_DEF = 8;

    localparam int SAMPLE_W    = 16;
    localparam int FRAME_LEN_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CNT_W       = 32;
    localparam int PHASE_W     = 30;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 128;

    // trim to step: q = floor(|trim| * 2^24 / 15625), via reciprocal and one correction
    localparam logic [26:0] STEP_RECIP  = 27'd70368744;
    localparam int          RECIP_SHIFT = 16;
    localparam logic [13:0] STEP_DIV    = 14'd15625;

    localparam logic FUNC_PUSH   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef enum logic [1:0] {
        ST_AUDIO     = 2'd0,
        ST_PREFILL   = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_FILL = 2'd0,
        CFG_TRIM_LIMIT  = 2'd1,
        CFG_PROP_GAIN   = 2'd2,
        CFG_INT_GAIN    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                       is_render;
        logic signed [SAMPLE_W-1:0] sample;
        logic [FRAME_LEN_W-1:0]     count;
    } cmd_t;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0]     count;
        status_t                    status;
        logic signed [SAMPLE_W-1:0] trim;
        logic [CNT_W-1:0]           underflows;
        logic [CNT_W-1:0]           prefills;
        logic [CNT_W-1:0]           clamps;
    } frame_desc_t;

    typedef enum logic [4:0] {
        CS_IDLE, CS_CHECK, CS_STEP1, CS_STEP2, CS_STEP3, CS_SPAN, CS_JUDGE,
        CS_READ, CS_MUL, CS_INTERP, CS_RAMP, CS_DIV, CS_WRITE, CS_END,
        CS_CT1, CS_CT2, CS_CT3, CS_CT4, CS_SEND
    } core_state_t;

    typedef enum logic [1:0] {
        OS_IDLE, OS_FETCH, OS_SEND
    } out_state_t;

endpackage

>>> hw/rtl/asrc_front.sv
// front end: accepts input requests, drops empty renders, saturates lengths
// and queues commands for the back end; depends on asrc_pkg
module asrc_front import asrc_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // push_sample[15:0], frame_length[22:16]
    input  logic                 s_axis_tuser,  // func
    output cmd_t                 cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_pop
);

    cmd_t                   q_mem [2];
    logic                   wp_reg, rp_reg;
    logic [1:0]             cnt_reg;
    logic                   accept, keep;
    logic [FRAME_LEN_W-1:0] len;
    cmd_t                   cmd_in;

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign len           = s_axis_tdata[22:16];
    // a render of zero samples changes nothing
    assign keep          = accept && ((s_axis_tuser == FUNC_PUSH) || (len != '0));

    always_comb
    begin
        cmd_in.is_render = (s_axis_tuser == FUNC_RENDER);
        cmd_in.sample    = s_axis_tdata[15:0];
        cmd_in.count     = (len > FRAME_LEN_W'(MAX_FRAME)) ? FRAME_LEN_W'(MAX_FRAME) : len;
    end

    assign cmd       = q_mem[rp_reg];
    assign cmd_valid = (cnt_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_mem[wp_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (keep)
            begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, keep} - {1'b0, cmd_pop};
        end
    end

endmodule

>>> hw/rtl/asrc_div.sv
// iterative restoring divider, one quotient bit per cycle, for the ramp scaling
// depends on asrc_pkg
module asrc_div import asrc_pkg::*; #(
    parameter int DW = 23,
    parameter int CW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int NW = $clog2(DW);

    logic [DW-1:0] quo_reg;
    logic [CW-1:0] rem_reg, den_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [CW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? CW'(trial - {1'b0, den_reg}) : trial[CW-1:0];
                quo_reg <= {quo_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg + NW'(1);
                if (cnt_reg == NW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/asrc_core.sv
// back end: sample ring, phase stepping, interpolation, ramp and fill controller
// depends on asrc_pkg; drives the frame buffer in asrc_out and uses asrc_div
module asrc_core import asrc_pkg::*; #(
    parameter int RING_DEPTH     = RING_DEPTH_DEF,
    parameter int MAX_FRAME      = MAX_FRAME_DEF,
    parameter int CONTROL_PERIOD = CONTROL_PERIOD_DEF,
    parameter int DW             = 23,
    parameter int CW             = 7,
    parameter int AW             = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  cmd_t                        cmd,
    input  logic                        cmd_valid,
    output logic                        cmd_pop,
    input  logic                        out_busy,
    output logic                        buf_we,
    output logic [AW-1:0]               buf_addr,
    output logic signed [SAMPLE_W-1:0]  buf_data,
    output logic                        desc_start,
    output frame_desc_t                 desc,
    output logic                        div_start,
    output logic [DW-1:0]               div_dividend,
    output logic [CW-1:0]               div_divisor,
    input  logic                        div_done,
    input  logic [DW-1:0]               div_quotient
);

    localparam int IW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int FCW = (CONTROL_PERIOD > 1) ? $clog2(CONTROL_PERIOD) : 1;
    localparam int SPW = 32 + CW;
    localparam int RQW = SPW - 29;
    localparam int CMW = FW + RQW;
    localparam int EW  = ((FW > 9) ? FW : 9) + 1;
    localparam int ACW = 34;

    // configuration
    logic [8:0]  target_reg;
    logic [14:0] limit_reg;
    logic [7:0]  pgain_reg;
    logic [15:0] igain_reg;

    // ring
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] x0_reg, x1_reg;
    logic                       ring_we, ring_rd;

    core_state_t                state_reg, state_next;
    logic [IW-1:0]              ri_reg, ri_next;
    logic [FW-1:0]              fill_reg, fill_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic                       prefilling_reg, prefilling_next;
    logic                       ramp_reg, ramp_next;
    logic [FCW-1:0]             fcnt_reg, fcnt_next;
    logic signed [31:0]         integral_reg, integral_next;
    logic signed [15:0]         trim_reg, trim_next;
    logic [CNT_W-1:0]           und_reg, und_next, pre_reg, pre_next, clamp_reg, clamp_next;
    logic [CW-1:0]              count_reg, count_next, idx_reg, idx_next;
    status_t                    status_reg, status_next;
    logic [41:0]                recip_reg, recip_next;
    logic [39:0]                qm_reg, qm_next;
    logic [30:0]                step_reg, step_next;
    logic [SPW-1:0]             span_reg, span_next;
    logic signed [47:0]         prod_reg, prod_next;
    logic signed [16:0]         v_reg, v_next;
    logic signed [EW+16:0]      pi_reg, pi_next;
    logic signed [EW+8:0]       pp_reg, pp_next;
    logic signed [31:0]         pint_reg, pint_next;

    logic [FW:0]                wsum, asum;
    logic [IW-1:0]              wr_pos, rd_pos1;
    logic [14:0]                mag;
    logic [38:0]                rem_w;
    logic [25:0]                q0_w;
    logic [RQW-1:0]             req_w;
    logic [31:0]                psum;
    logic [1:0]                 adv, adv_eff;
    logic signed [EW-1:0]       err;
    logic signed [ACW-1:0]      acc_sum, ilim, lim_w, prop_w, t_w;
    logic signed [17:0]         v_w;
    logic [15:0]                vmag, q16;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)
            return 16'sh7FFF;
        else if (v < -17'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // ring positions
    assign wsum    = (FW + 1)'(ri_reg) + (FW + 1)'(fill_reg);
    assign wr_pos  = (wsum >= (FW + 1)'(RING_DEPTH)) ? IW'(wsum - (FW + 1)'(RING_DEPTH))
                                                     : wsum[IW-1:0];
    assign rd_pos1 = (ri_reg == IW'(RING_DEPTH - 1)) ? '0 : ri_reg + IW'(1);

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_pos] <= cmd.sample;
        end
        if (ring_rd)
        begin
            x0_reg <= ring_mem[ri_reg];
            x1_reg <= ring_mem[rd_pos1];
        end
    end

    // shared combinational terms
    assign mag     = trim_reg[15] ? 15'(-trim_reg) : trim_reg[14:0];
    assign q0_w    = recip_reg[41:RECIP_SHIFT];
    assign rem_w   = {mag, 24'b0} - qm_reg[38:0];
    assign req_w   = RQW'(span_reg[SPW-1:PHASE_W]) + RQW'(2);
    assign psum    = 32'(phase_reg) + 32'(step_reg);
    assign adv     = psum[31:30];
    assign adv_eff = (fill_reg < FW'(adv)) ? fill_reg[1:0] : adv;
    assign asum    = (FW + 1)'(ri_reg) + (FW + 1)'(adv_eff);
    assign err     = $signed(EW'(fill_reg)) - $signed(EW'(target_reg));
    assign acc_sum = ACW'(integral_reg) + ACW'(pi_reg);
    assign ilim    = $signed({3'b0, limit_reg, 16'b0});
    assign lim_w   = $signed(ACW'(limit_reg));
    assign prop_w  = ACW'(pp_reg) + ACW'(pint_reg >>> 16);
    assign t_w     = ACW'(pp_reg) + ACW'(integral_reg >>> 16);
    assign v_w     = $signed({{2{x0_reg[15]}}, x0_reg}) + $signed(prod_reg[47:30]);
    assign vmag    = v_reg[16] ? 16'(-v_reg) : v_reg[15:0];
    assign q16     = div_quotient[15:0];

    assign buf_addr     = idx_reg[AW-1:0];
    assign buf_data     = sat16(v_reg);
    assign div_dividend = {CW'(0), vmag} * {16'b0, idx_reg};
    assign div_divisor  = count_reg - CW'(1);

    always_comb
    begin
        desc.count      = FRAME_LEN_W'(count_reg);
        desc.status     = status_reg;
        desc.trim       = trim_reg;
        desc.underflows = und_reg;
        desc.prefills   = pre_reg;
        desc.clamps     = clamp_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        ri_next         = ri_reg;
        fill_next       = fill_reg;
        phase_next      = phase_reg;
        prefilling_next = prefilling_reg;
        ramp_next       = ramp_reg;
        fcnt_next       = fcnt_reg;
        integral_next   = integral_reg;
        trim_next       = trim_reg;
        und_next        = und_reg;
        pre_next        = pre_reg;
        clamp_next      = clamp_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        recip_next      = recip_reg;
        qm_next         = qm_reg;
        step_next       = step_reg;
        span_next       = span_reg;
        prod_next       = prod_reg;
        v_next          = v_reg;
        pi_next         = pi_reg;
        pp_next         = pp_reg;
        pint_next       = pint_reg;
        cmd_pop         = 1'b0;
        ring_we         = 1'b0;
        ring_rd         = 1'b0;
        buf_we          = 1'b0;
        desc_start      = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            CS_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_render)
                    begin
                        cmd_pop = 1'b1;
                        // push into a full ring is dropped
                        if (fill_reg < FW'(RING_DEPTH))
                        begin
                            ring_we   = 1'b1;
                            fill_next = fill_reg + FW'(1);
                        end
                    end
                    else if (!out_busy)
                    begin
                        cmd_pop    = 1'b1;
                        count_next = cmd.count[CW-1:0];
                        state_next = CS_CHECK;
                    end
                end
            end
            CS_CHECK:
            begin
                if (prefilling_reg && (EW'(fill_reg) < EW'(target_reg)))
                begin
                    status_next = ST_PREFILL;
                    state_next  = CS_SEND;
                end
                else
                begin
                    status_next = ST_AUDIO;
                    if (prefilling_reg)
                    begin
                        prefilling_next = 1'b0;
                        ramp_next       = 1'b1;
                        phase_next      = '0;
                        pre_next        = pre_reg + CNT_W'(1);
                    end
                    state_next = CS_STEP1;
                end
            end
            CS_STEP1:
            begin
                recip_next = 42'(mag) * 42'(STEP_RECIP);
                state_next = CS_STEP2;
            end
            CS_STEP2:
            begin
                qm_next    = 40'(q0_w) * 40'(STEP_DIV);
                state_next = CS_STEP3;
            end
            CS_STEP3:
            begin
                if (rem_w >= 39'(STEP_DIV))
                begin
                    step_next = trim_reg[15] ? 31'(32'h4000_0000 - 32'(q0_w) - 32'd1)
                                             : 31'(32'h4000_0000 + 32'(q0_w) + 32'd1);
                end
                else
                begin
                    step_next = trim_reg[15] ? 31'(32'h4000_0000 - 32'(q0_w))
                                             : 31'(32'h4000_0000 + 32'(q0_w));
                end
                state_next = CS_SPAN;
            end
            CS_SPAN:
            begin
                span_next  = SPW'(phase_reg) + SPW'(step_reg) * SPW'(count_reg);
                state_next = CS_JUDGE;
            end
            CS_JUDGE:
            begin
                if (CMW'(fill_reg) < CMW'(req_w))
                begin
                    status_next     = ST_UNDERFLOW;
                    und_next        = und_reg + CNT_W'(1);
                    prefilling_next = 1'b1;
                    ramp_next       = 1'b1;
                    integral_next   = '0;
                    trim_next       = '0;
                    clamp_next      = '0;
                    phase_next      = '0;
                    state_next      = CS_SEND;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = CS_READ;
                end
            end
            CS_READ:
            begin
                ring_rd    = 1'b1;
                state_next = CS_MUL;
            end
            CS_MUL:
            begin
                prod_next  = ($signed({x1_reg[15], x1_reg}) - $signed({x0_reg[15], x0_reg}))
                             * $signed({1'b0, phase_reg});
                state_next = CS_INTERP;
            end
            CS_INTERP:
            begin
                v_next = v_w[16:0];
                if (ramp_reg && (count_reg > CW'(1)))
                    state_next = CS_RAMP;
                else
                    state_next = CS_WRITE;
            end
            CS_RAMP:
            begin
                div_start  = 1'b1;
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                if (div_done)
                begin
                    // truncation toward zero: divide the magnitude, restore the sign
                    v_next     = v_reg[16] ? -$signed({1'b0, q16}) : $signed({1'b0, q16});
                    state_next = CS_WRITE;
                end
            end
            CS_WRITE:
            begin
                buf_we     = 1'b1;
                phase_next = psum[PHASE_W-1:0];
                if (adv != 2'd0)
                begin
                    ri_next   = (asum >= (FW + 1)'(RING_DEPTH))
                                ? IW'(asum - (FW + 1)'(RING_DEPTH)) : asum[IW-1:0];
                    fill_next = fill_reg - FW'(adv_eff);
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == count_reg - CW'(1))
                    state_next = CS_END;
                else
                    state_next = CS_READ;
            end
            CS_END:
            begin
                ramp_next = 1'b0;
                if (fcnt_reg == FCW'(CONTROL_PERIOD - 1))
                begin
                    fcnt_next  = '0;
                    state_next = CS_CT1;
                end
                else
                begin
                    fcnt_next  = fcnt_reg + FCW'(1);
                    state_next = CS_SEND;
                end
            end
            CS_CT1:
            begin
                pi_next    = err * $signed({1'b0, igain_reg});
                pp_next    = err * $signed({1'b0, pgain_reg});
                state_next = CS_CT2;
            end
            CS_CT2:
            begin
                if (acc_sum > ilim)
                    pint_next = 32'(ilim);
                else if (acc_sum < -ilim)
                    pint_next = 32'(-ilim);
                else
                    pint_next = 32'(acc_sum);
                state_next = CS_CT3;
            end
            CS_CT3:
            begin
                // anti-windup: while clamped, keep the new integral only when it pulls away from the clamp
                if ((prop_w > lim_w) || (prop_w < -lim_w))
                begin
                    clamp_next = clamp_reg + CNT_W'(1);
                    if (((prop_w > lim_w) && (err < 0)) || ((prop_w < -lim_w) && (err > 0)))
                        integral_next = pint_reg;
                end
                else
                begin
                    integral_next = pint_reg;
                end
                state_next = CS_CT4;
            end
            CS_CT4:
            begin
                if (t_w > lim_w)
                    trim_next = 16'(lim_w);
                else if (t_w < -lim_w)
                    trim_next = 16'(-lim_w);
                else
                    trim_next = 16'(t_w);
                state_next = CS_SEND;
            end
            CS_SEND:
            begin
                desc_start = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 9'd128;
            limit_reg  <= 15'd1000;
            pgain_reg  <= 8'd8;
            igain_reg  <= 16'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TARGET_FILL: target_reg <= cfg_data[8:0];
                CFG_TRIM_LIMIT:  limit_reg  <= cfg_data[14:0];
                CFG_PROP_GAIN:   pgain_reg  <= cfg_data[7:0];
                CFG_INT_GAIN:    igain_reg  <= cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CS_IDLE;
            ri_reg         <= '0;
            fill_reg       <= '0;
            phase_reg      <= '0;
            prefilling_reg <= 1'b1;
            ramp_reg       <= 1'b1;
            fcnt_reg       <= '0;
            integral_reg   <= '0;
            trim_reg       <= '0;
            und_reg        <= '0;
            pre_reg        <= '0;
            clamp_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            status_reg     <= ST_AUDIO;
        end
        else
        begin
            state_reg      <= state_next;
            ri_reg         <= ri_next;
            fill_reg       <= fill_next;
            phase_reg      <= phase_next;
            prefilling_reg <= prefilling_next;
            ramp_reg       <= ramp_next;
            fcnt_reg       <= fcnt_next;
            integral_reg   <= integral_next;
            trim_reg       <= trim_next;
            und_reg        <= und_next;
            pre_reg        <= pre_next;
            clamp_reg      <= clamp_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= recip_next;
        qm_reg    <= qm_next;
        step_reg  <= step_next;
        span_reg  <= span_next;
        prod_reg  <= prod_next;
        v_reg     <= v_next;
        pi_reg    <= pi_next;
        pp_reg    <= pp_next;
        pint_reg  <= pint_next;
    end

endmodule

>>> hw/rtl/asrc_out.sv
// frame buffer and output stream: holds one rendered frame and sends it
// with the frame status and counters; depends on asrc_pkg
module asrc_out import asrc_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int AW        = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       buf_we,
    input  logic [AW-1:0]              buf_addr,
    input  logic signed [SAMPLE_W-1:0] buf_data,
    input  logic                       desc_start,
    input  frame_desc_t                desc,
    output logic                       busy,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // out_sample, trim_now, underflows_seen, prefills_done, clamp_events
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic [1:0]                 m_axis_tuser  // status
);

    logic signed [SAMPLE_W-1:0] frame_mem [MAX_FRAME];
    logic signed [SAMPLE_W-1:0] rd_reg;
    frame_desc_t                desc_reg;
    out_state_t                 state_reg, state_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic                       fetch, last;
    logic [SAMPLE_W-1:0]        sample;

    assign busy   = (state_reg != OS_IDLE);
    assign last   = ((FRAME_LEN_W'(idx_reg) + FRAME_LEN_W'(1)) == desc_reg.count);
    // zeros go out in prefill and underflow frames
    assign sample = (desc_reg.status == ST_AUDIO) ? rd_reg : '0;

    assign m_axis_tdata = {desc_reg.clamps, desc_reg.prefills, desc_reg.underflows,
                           desc_reg.trim, sample};
    assign m_axis_tlast = last;
    assign m_axis_tuser = desc_reg.status;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            frame_mem[buf_addr] <= buf_data;
        end
        if (fetch)
        begin
            rd_reg <= frame_mem[idx_reg];
        end
        if (desc_start)
        begin
            desc_reg <= desc;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fetch         = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            OS_IDLE:
            begin
                if (desc_start)
                begin
                    idx_next   = '0;
                    state_next = OS_FETCH;
                end
            end
            OS_FETCH:
            begin
                fetch      = 1'b1;
                state_next = OS_SEND;
            end
            OS_SEND:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (last)
                    begin
                        state_next = OS_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = OS_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = OS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OS_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> hw/rtl/asrc_linear_resampler_pi.sv
// top level of the adaptive linear-interpolation resampler
// depends on asrc_pkg, asrc_front, asrc_div, asrc_core and asrc_out
//
// usage
//   s_axis carries requests: tuser 0 pushes tdata[15:0] into the sample ring,
//   tuser 1 renders a frame of tdata[22:16] samples (above MAX_FRAME is cut to
//   MAX_FRAME, zero gives nothing). a push into a full ring is dropped.
//   m_axis returns one beat per rendered sample, tlast on the final one, tuser
//   the frame status (audio, prefill, underflow) and tdata the sample, the
//   trim and the three event counters as they stand after the frame.
//   cfg_we writes cfg_data into register cfg_index at once; the user must write
//   only while idle, which the block does not enforce. a two-entry command
//   queue sits in front of the back end, so requests are taken while a frame
//   is still being sent. a push is a single ring write. a render runs a setup
//   (check, step, span, judge), then per sample a ring read, multiply,
//   interpolate and buffer write, with a bit-serial divide in a ramped frame,
//   and a controller update in every CONTROL_PERIOD-th audio frame. each beat
//   is fetched through the single read port of the frame buffer before it is
//   sent. a render waits in the queue until the previous frame has been sent.
//   a stalled receiver holds the current beat; the queue then fills and
//   s_axis_tready falls. reset empties everything, arms prefill and ramp,
//   clears the controller and counters and loads the register defaults.
module asrc_linear_resampler_pi import asrc_pkg::*; #(
    parameter int RING_DEPTH     = RING_DEPTH_DEF,
    parameter int MAX_FRAME      = MAX_FRAME_DEF,
    parameter int CONTROL_PERIOD = CONTROL_PERIOD_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // push_sample[15:0], frame_length[22:16]
    input  logic                  s_axis_tuser,  // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_sample[15:0], trim_now[31:16], underflows_seen[63:32],
    // prefills_done[95:64], clamp_events[127:96]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,  // last
    output logic [1:0]            m_axis_tuser   // status
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int DW = SAMPLE_W + CW;

    cmd_t                       cmd;
    logic                       cmd_valid, cmd_pop;
    logic                       out_busy, buf_we, desc_start;
    logic [AW-1:0]              buf_addr;
    logic signed [SAMPLE_W-1:0] buf_data;
    frame_desc_t                desc;
    logic                       div_start, div_done;
    logic [DW-1:0]              div_dividend, div_quotient;
    logic [CW-1:0]              div_divisor;

    asrc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop)
    );

    asrc_div #(
        .DW (DW),
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    asrc_core #(
        .RING_DEPTH     (RING_DEPTH),
        .MAX_FRAME      (MAX_FRAME),
        .CONTROL_PERIOD (CONTROL_PERIOD),
        .DW             (DW),
        .CW             (CW),
        .AW             (AW)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .out_busy     (out_busy),
        .buf_we       (buf_we),
        .buf_addr     (buf_addr),
        .buf_data     (buf_data),
        .desc_start   (desc_start),
        .desc         (desc),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient)
    );

    asrc_out #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .buf_we        (buf_we),
        .buf_addr      (buf_addr),
        .buf_data      (buf_data),
        .desc_start    (desc_start),
        .desc          (desc),
        .busy          (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> dv/asrc_resampler_checker.sv
`timescale 1ns / 1ps
// checker for the linear resampler: watches config writes and both streams,
// predicts every output beat and compares it field by field; needs asrc_pkg
module asrc_resampler_checker import asrc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic [1:0]            m_axis_tuser,
    output int                    fail_count,
    output int                    beats_pending
);

    localparam int RING = RING_DEPTH_DEF;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef struct {
        logic [15:0] sample;
        logic        last;
        status_t     status;
        logic [15:0] trim;
        logic [31:0] underflows;
        logic [31:0] prefills;
        logic [31:0] clamps;
    } beat_t;

    beat_t beat_q[$];

    // mirror of the resampler state
    logic signed [15:0] ring_mem [RING];
    int unsigned     rd_idx;
    int unsigned     fill;
    longint unsigned phase_frac;
    bit              in_prefill;
    bit              ramp_armed;
    int unsigned     frame_cnt;
    longint          integ_q16;
    longint          trim;
    logic [31:0]     uf_total, pf_total, cl_total;
    int unsigned     tgt_fill, trim_lim, p_gain, i_gain;

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic void clear_loop();
        integ_q16 = 0;
        trim      = 0;
        cl_total  = 0;
    endfunction

    function automatic void update_trim();
        longint lim, err, pint, prop, proposed;
        lim      = trim_lim;
        err      = longint'(fill) - longint'(tgt_fill);
        pint     = clamp_sym(integ_q16 + err * longint'(i_gain), lim * 65536);
        prop     = err * longint'(p_gain);
        proposed = prop + (pint >>> 16);
        if (proposed > lim || proposed < -lim) begin
            cl_total++;
            // anti-windup: only integrate when it pulls back out of the clamp
            if ((proposed > lim && err < 0) || (proposed < -lim && err > 0))
                integ_q16 = pint;
        end
        else
            integ_q16 = pint;
        trim = clamp_sym(prop + (integ_q16 >>> 16), lim);
    endfunction

    function automatic void resample_request(logic is_render, logic signed [15:0] smp,
                                             logic [6:0] len);
        longint          frame_out [64];
        int unsigned     n;
        status_t         st;
        longint          step, x0, x1, v;
        longint unsigned ph, adv, span;
        beat_t           b;
        if (is_render == FUNC_PUSH) begin
            if (fill < RING) begin
                ring_mem[(rd_idx + fill) % RING] = smp;
                fill++;
            end
            return;
        end
        n = len;
        if (n == 0)
            return;
        if (n > MAX_FRAME_DEF)
            n = MAX_FRAME_DEF;
        for (int i = 0; i < 64; i++)
            frame_out[i] = 0;
        st = ST_AUDIO;
        if (in_prefill && fill < tgt_fill)
            st = ST_PREFILL;
        else begin
            if (in_prefill) begin
                in_prefill = 0;
                ramp_armed = 1;
                phase_frac = 0;
                pf_total++;
            end
            step = ONE_Q30 + (trim * ONE_Q30) / 1000000;
            span = phase_frac + longint'(step) * n;
            if (longint'(fill) < longint'((span >> 30) + 2)) begin
                st = ST_UNDERFLOW;
                uf_total++;
                in_prefill = 1;
                ramp_armed = 1;
                clear_loop();
                phase_frac = 0;
            end
            else begin
                ph = phase_frac;
                for (int i = 0; i < n; i++) begin
                    x0 = ring_mem[rd_idx % RING];
                    x1 = ring_mem[(rd_idx + 1) % RING];
                    v  = x0 + (((x1 - x0) * longint'(ph & (ONE_Q30 - 1))) >>> 30);
                    if (ramp_armed && n > 1)
                        v = (v * i) / longint'(n - 1);
                    frame_out[i] = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
                    ph  = ph + step;
                    adv = ph >> 30;
                    if (adv > 0) begin
                        if (adv > fill)
                            adv = fill;
                        rd_idx = (rd_idx + adv) % RING;
                        fill   = fill - adv;
                        ph     = ph & (ONE_Q30 - 1);
                    end
                end
                phase_frac = ph & (ONE_Q30 - 1);
                ramp_armed = 0;
                frame_cnt++;
                if (frame_cnt >= CONTROL_PERIOD_DEF) begin
                    frame_cnt = 0;
                    update_trim();
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            b.sample     = frame_out[i][15:0];
            b.last       = (i + 1 == n);
            b.status     = st;
            b.trim       = trim[15:0];
            b.underflows = uf_total;
            b.prefills   = pf_total;
            b.clamps     = cl_total;
            beat_q.push_back(b);
        end
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                     exp_v, act_v);
            fail_count++;
        end
    endfunction

    assign beats_pending = beat_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        beat_t b;
        if (!rst_n) begin
            beat_q.delete();
            rd_idx     = 0;
            fill       = 0;
            phase_frac = 0;
            in_prefill = 1;
            ramp_armed = 1;
            frame_cnt  = 0;
            clear_loop();
            uf_total   = 0;
            pf_total   = 0;
            tgt_fill   = 128;
            trim_lim   = 1000;
            p_gain     = 8;
            i_gain     = 128;
        end
        else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TARGET_FILL: tgt_fill = cfg_data[8:0];
                    CFG_TRIM_LIMIT:  trim_lim = cfg_data[14:0];
                    CFG_PROP_GAIN:   p_gain   = cfg_data[7:0];
                    CFG_INT_GAIN:    i_gain   = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                resample_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[22:16]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (beat_q.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, got %0h",
                             $realtime, m_axis_tdata);
                    fail_count++;
                end
                else begin
                    b = beat_q.pop_front();
                    check_field("out_sample", b.sample, m_axis_tdata[15:0]);
                    check_field("trim_now", b.trim, m_axis_tdata[31:16]);
                    check_field("underflows_seen", b.underflows, m_axis_tdata[63:32]);
                    check_field("prefills_done", b.prefills, m_axis_tdata[95:64]);
                    check_field("clamp_events", b.clamps, m_axis_tdata[127:96]);
                    check_field("last", b.last, m_axis_tlast);
                    check_field("status", b.status, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
    end

endmodule

>>> dv/tb_asrc_linear_resampler_pi.sv
`timescale 1ns / 1ps
// top of the resampler testbench: clock, reset, requests, config phases
// and the verdict; depends on asrc_pkg, the block and asrc_resampler_checker
module tb_asrc_linear_resampler_pi;
    import asrc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // push_sample[15:0], frame_length[22:16]
    logic                  s_axis_tuser;   // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // out_sample[15:0], trim_now[31:16], underflows_seen[63:32],
    // prefills_done[95:64], clamp_events[127:96]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;   // last
    logic [1:0]            m_axis_tuser;   // status
    int                    fail_count;
    int                    beats_pending;
    int                    cycles;
    bit                    no_gaps;

    asrc_linear_resampler_pi dut (.*);
    asrc_resampler_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("asrc_linear_resampler_pi regression: fail");
            $finish;
        end
    end

    // receiver: random stall before each beat, unless no_gaps is set
    initial
    begin
        int gap;
        m_axis_tready = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_req(logic func, logic [15:0] smp, logic [6:0] len);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {1'b0, len, smp};
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic push(logic [15:0] smp);
        send_req(FUNC_PUSH, smp, 7'($urandom_range(0, 127)));
    endtask

    task automatic render(logic [6:0] len);
        send_req(FUNC_RENDER, 16'($urandom), len);
    endtask

    // drain the block before touching registers
    task automatic go_idle();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(int tgt, int lim, int pg, int ig);
        cfg_we    <= 1;
        cfg_index <= CFG_TARGET_FILL;
        cfg_data  <= 16'(tgt);
        @(posedge clk);
        cfg_index <= CFG_TRIM_LIMIT;
        cfg_data  <= 16'(lim);
        @(posedge clk);
        cfg_index <= CFG_PROP_GAIN;
        cfg_data  <= 16'(pg);
        @(posedge clk);
        cfg_index <= CFG_INT_GAIN;
        cfg_data  <= 16'(ig);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58)
            push(r < 4 ? (r[0] ? 16'h7fff : 16'h8000) : 16'($urandom));
        else if (r < 93)
            render(7'($urandom_range(1, 8)));
        else if (r < 97)
            render(7'($urandom_range(9, 64)));
        else
            render(7'($urandom_range(0, 127)));
    endtask

    task automatic run_phase(int tgt, int lim, int pg, int ig, int n_items);
        go_idle();
        write_regs(tgt, lim, pg, ig);
        no_gaps = ($urandom_range(0, 3) == 0);
        // well-formed start: reach the target, then mixed traffic
        repeat (tgt + 4) push(16'($urandom));
        repeat (n_items) random_req();
    endtask

    initial
    begin
        rst_n         = 0;
        cfg_we        = 0;
        cfg_index     = CFG_TARGET_FILL;
        cfg_data      = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tuser  = FUNC_PUSH;
        no_gaps       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: prefill, empty and oversized frames, extreme samples,
        // ramped frame, single-sample ramp, underflow restart
        write_regs(3, 1000, 8, 128);
        render(5);
        render(0);
        push(16'h7fff);
        push(16'h8000);
        push(16'h5555);
        push(16'haaaa);
        push(16'hffff);
        push(16'h0000);
        render(3);
        render(1);
        render(127);
        push(16'h8000);
        push(16'h7fff);
        push(16'h1234);
        push(16'hedcb);
        render(1);
        render(64);

        run_phase(64, 1000, 8, 128, 40);
        run_phase(0, 0, 0, 0, 35);
        run_phase(16, 32767, 255, 65535, 40);
        run_phase(4, 500, 40, 4000, 20);

        go_idle();
        if (fail_count == 0)
            $display("asrc_linear_resampler_pi regression: pass");
        else
            $display("asrc_linear_resampler_pi regression: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/asrc_pkg.sv
hw/rtl/asrc_front.sv
hw/rtl/asrc_div.sv
hw/rtl/asrc_core.sv
hw/rtl/asrc_out.sv
hw/rtl/asrc_linear_resampler_pi.sv
dv/asrc_resampler_checker.sv
dv/tb_asrc_linear_resampler_pi.sv
